### design/fcb_pkg.sv
`default_nettype none
package fcb_pkg;

    localparam int VAL_W  = 26;
    localparam int PRIO_W = 23;
    localparam int PT_W   = 16;

    typedef logic [VAL_W-1:0]  val_t;
    typedef logic [PRIO_W-1:0] prio_t;
    typedef logic [2:0]        cmd_t;

    localparam val_t  VAL_MAX  = {VAL_W{1'b1}};
    localparam prio_t PRIO_MAX = {PRIO_W{1'b1}};

    localparam cmd_t CMD_LOAD    = 3'd0;
    localparam cmd_t CMD_PREP    = 3'd1;
    localparam cmd_t CMD_CLEAR   = 3'd2;
    localparam cmd_t CMD_FRONT   = 3'd3;
    localparam cmd_t CMD_BACK    = 3'd4;
    localparam cmd_t CMD_UNSCHED = 3'd5;
    localparam cmd_t CMD_CHILD   = 3'd6;
    localparam cmd_t CMD_NODE    = 3'd7;

    localparam logic CFG_JOB_COUNT     = 1'b0;
    localparam logic CFG_MACHINE_COUNT = 1'b1;

    typedef struct packed {
        logic start;
        val_t num;
        val_t den;
    } div_req_t;

    typedef struct packed {
        logic  done;
        prio_t quot;
    } div_rsp_t;

    function automatic val_t sat_add(input val_t a, input val_t b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VAL_W] ? VAL_MAX : s[VAL_W-1:0];
    endfunction

    function automatic val_t sat_add3(input val_t a, input val_t b, input val_t c);
        logic [VAL_W+1:0] s;
        s = {2'b00, a} + {2'b00, b} + {2'b00, c};
        return (s[VAL_W+1:VAL_W] != 2'b00) ? VAL_MAX : s[VAL_W-1:0];
    endfunction

    function automatic prio_t prio_add(input prio_t a, input prio_t b);
        logic [PRIO_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PRIO_W] ? PRIO_MAX : s[PRIO_W-1:0];
    endfunction

    function automatic val_t umax(input val_t a, input val_t b);
        return (a > b) ? a : b;
    endfunction

endpackage
`default_nettype wire

### design/fcb_divider.sv
`default_nettype none
module fcb_divider #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fcb_pkg::div_req_t req,
    output fcb_pkg::div_rsp_t      rsp
);
    import fcb_pkg::*;

    localparam int QW = VAL_W + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0]  dvd_reg;
    logic [QW-1:0]  quo_reg;
    logic [VAL_W:0] rem_reg;
    val_t           den_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [VAL_W:0] rem_sh;
    logic           qbit;

    assign rem_sh = {rem_reg[VAL_W-1:0], dvd_reg[QW-1]};
    assign qbit   = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                dvd_reg  <= {req.num, {FRAC_BITS{1'b0}}};
                rem_reg  <= '0;
                quo_reg  <= '0;
                den_reg  <= req.den;
                cnt_reg  <= CW'(QW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= qbit ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                dvd_reg <= {dvd_reg[QW-2:0], 1'b0};
                quo_reg <= {quo_reg[QW-2:0], qbit};
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = (den_reg == '0) ? '0 :
                      ((|quo_reg[QW-1:PRIO_W]) ? PRIO_MAX : quo_reg[PRIO_W-1:0]);

endmodule
`default_nettype wire

### design/flowshop_child_bound_engine.sv
// Load and clear complete in the idle state; add front/back/unscheduled and node query
// walk the machines once; prepare walks all jobs forward and then backward; child query
// makes a forward and a backward pass (one division per pass when m=1).
// Throughput is set by the one shared bit-serial divider; one request at a time, and a new
// request is taken while a result waits at the output.
// Reset (rst_n, async, active low) clears schedule and used flags, resets control state.
`default_nettype none
module flowshop_child_bound_engine #(
    parameter int MAX_JOBS     = 256,
    parameter int MAX_MACHINES = 32,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,  // command, job, machine, proc_time
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [159:0]      m_axis_tdata,  // job_echo, bound_begin, bound_end,
                                             // prio_begin, prio_end, node_bound,
                                             // last_finish, zero pad
    output logic              m_axis_tuser,  // kind
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [8:0]   cfg_data
);
    import fcb_pkg::*;

    localparam int JB = $clog2(MAX_JOBS);
    localparam int MB = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int AW = JB + MB;
    localparam int MEM_DEPTH = MAX_JOBS * (2 ** MB);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP_INIT, ST_FETCH, ST_CALC, ST_CALC2, ST_DIV1, ST_WAIT1,
        ST_DIV2, ST_WAIT2, ST_NODE, ST_NEXT, ST_RESULT
    } state_t;

    state_t         state_reg;
    cmd_t           op_reg;
    logic [7:0]     job_reg;
    logic [JB-1:0]  jaddr_reg;
    logic [JB-1:0]  i_reg;
    logic           in_range_reg;
    logic           dir_reg;
    logic [MB-1:0]  j_reg;
    val_t           t0_reg, t1_reg, idm_reg, lb_acc_reg, lbf_reg;
    prio_t          p_reg, pf_reg;
    logic           front_used_reg, back_used_reg;
    logic [8:0]     job_count_reg;
    logic [5:0]     machine_count_reg;

    val_t ff_reg [MAX_MACHINES];
    val_t bf_reg [MAX_MACHINES];
    val_t fi_reg [MAX_MACHINES];
    val_t bi_reg [MAX_MACHINES];
    val_t rw_reg [MAX_MACHINES];
    val_t mh_reg [MAX_MACHINES];
    val_t mt_reg [MAX_MACHINES];

    logic [PT_W-1:0] mem [MEM_DEPTH];
    logic [PT_W-1:0] rdata_reg;
    logic [AW-1:0]   raddr;

    logic           out_valid_reg;
    logic           kind_reg;
    logic [7:0]     echo_reg;
    val_t           bb_reg, be_reg, nb_reg, lf_reg;
    prio_t          pb_reg, pe_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    cmd_t           in_cmd;
    logic [7:0]     in_job;
    logic [4:0]     in_mach;
    logic [PT_W-1:0] in_pt;
    logic           accept;
    logic           in_job_ok;
    logic           load_we;

    logic [31:0]    jc32, mc32, nj32, nm32;
    logic [JB-1:0]  nj_last;
    logic [MB-1:0]  m_last;
    logic           is_first, is_last;

    val_t pt, ff_j, bf_j, fi_j, bi_j, rw_j, ef_j, eb_j, a_j, b_j, idle_a, idle_b;
    val_t prev, cur, t1_next, idm_next, lb_next;

    assign in_cmd  = s_axis_tdata[2:0];
    assign in_job  = s_axis_tdata[10:3];
    assign in_mach = s_axis_tdata[15:11];
    assign in_pt   = s_axis_tdata[31:16];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_job_ok     = (32'(in_job) < 32'(MAX_JOBS));
    assign load_we       = accept && (in_cmd == CMD_LOAD) && in_job_ok
                           && (32'(in_mach) < 32'(MAX_MACHINES));

    always_comb
    begin
        jc32 = 32'(job_count_reg);
        mc32 = 32'(machine_count_reg);
        if (jc32 == 32'd0)
            nj32 = 32'd1;
        else if (jc32 > 32'(MAX_JOBS))
            nj32 = 32'(MAX_JOBS);
        else
            nj32 = jc32;
        if (mc32 == 32'd0)
            nm32 = 32'd1;
        else if (mc32 > 32'(MAX_MACHINES))
            nm32 = 32'(MAX_MACHINES);
        else
            nm32 = mc32;
    end

    assign nj_last  = JB'(nj32 - 32'd1);
    assign m_last   = MB'(nm32 - 32'd1);
    assign is_first = dir_reg ? (j_reg == m_last) : (j_reg == '0);
    assign is_last  = dir_reg ? (j_reg == '0) : (j_reg == m_last);

    assign raddr = {((op_reg == CMD_PREP) ? i_reg : jaddr_reg), j_reg};

    always_ff @(posedge clk)
    begin
        if (load_we)
            mem[{JB'(in_job), MB'(in_mach)}] <= in_pt;
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        pt     = in_range_reg ? {{(VAL_W-PT_W){1'b0}}, rdata_reg} : '0;
        ff_j   = ff_reg[j_reg];
        bf_j   = bf_reg[j_reg];
        fi_j   = fi_reg[j_reg];
        bi_j   = bi_reg[j_reg];
        rw_j   = rw_reg[j_reg];
        ef_j   = front_used_reg ? ff_j : mh_reg[j_reg];
        eb_j   = back_used_reg ? bf_j : mt_reg[j_reg];
        a_j    = dir_reg ? eb_j : ef_j;
        b_j    = dir_reg ? ef_j : eb_j;
        idle_a = dir_reg ? bi_j : fi_j;
        idle_b = dir_reg ? fi_j : bi_j;
        prev   = is_first ? '0 : t0_reg;
        cur    = dir_reg ? bf_j : ff_j;
        t1_next  = is_first ? a_j : umax(a_j, t0_reg);
        idm_next = sat_add(idle_a, (t0_reg > a_j) ? (t0_reg - a_j) : '0);
        lb_next  = sat_add3(t1_reg, rw_j, b_j);
    end

    always_comb
    begin
        div_req.start = (state_reg == ST_DIV1) || (state_reg == ST_DIV2);
        div_req.num   = (state_reg == ST_DIV1) ? idm_reg : idle_b;
        div_req.den   = (state_reg == ST_DIV1) ? t0_reg : b_j;
    end

    fcb_divider #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PREP_INIT)
        begin
            for (int k = 0; k < MAX_MACHINES; k++)
            begin
                mh_reg[k] <= (k == 0) ? '0 : VAL_MAX;
                mt_reg[k] <= (MB'(k) == m_last) ? '0 : VAL_MAX;
            end
        end
        else if (state_reg == ST_CALC && op_reg == CMD_PREP && !is_first)
        begin
            if (!dir_reg)
                mh_reg[j_reg] <= (t0_reg < mh_reg[j_reg]) ? t0_reg : mh_reg[j_reg];
            else
                mt_reg[j_reg] <= (t0_reg < mt_reg[j_reg]) ? t0_reg : mt_reg[j_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            op_reg            <= CMD_LOAD;
            dir_reg           <= 1'b0;
            j_reg             <= '0;
            i_reg             <= '0;
            in_range_reg      <= 1'b0;
            front_used_reg    <= 1'b0;
            back_used_reg     <= 1'b0;
            job_count_reg     <= 9'd256;
            machine_count_reg <= 6'd32;
            out_valid_reg     <= 1'b0;
            for (int k = 0; k < MAX_MACHINES; k++)
            begin
                ff_reg[k] <= '0;
                bf_reg[k] <= '0;
                fi_reg[k] <= '0;
                bi_reg[k] <= '0;
                rw_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_JOB_COUNT:     job_count_reg <= cfg_data;
                    CFG_MACHINE_COUNT: machine_count_reg <= cfg_data[5:0];
                    default:           job_count_reg <= job_count_reg;
                endcase
            end
            if (state_reg == ST_RESULT && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg       <= in_cmd;
                        job_reg      <= in_job;
                        jaddr_reg    <= JB'(in_job);
                        in_range_reg <= in_job_ok || (in_cmd == CMD_PREP);
                        dir_reg      <= (in_cmd == CMD_BACK);
                        j_reg        <= (in_cmd == CMD_BACK) ? m_last : '0;
                        t0_reg       <= '0;
                        lb_acc_reg   <= '0;
                        p_reg        <= '0;
                        case (in_cmd)
                            CMD_LOAD:  state_reg <= ST_IDLE;
                            CMD_PREP:  state_reg <= ST_PREP_INIT;
                            CMD_CLEAR:
                            begin
                                for (int k = 0; k < MAX_MACHINES; k++)
                                begin
                                    ff_reg[k] <= '0;
                                    bf_reg[k] <= '0;
                                    fi_reg[k] <= '0;
                                    bi_reg[k] <= '0;
                                    rw_reg[k] <= '0;
                                end
                                front_used_reg <= 1'b0;
                                back_used_reg  <= 1'b0;
                            end
                            CMD_NODE:  state_reg <= ST_NODE;
                            default:   state_reg <= ST_FETCH;
                        endcase
                    end
                end
                ST_PREP_INIT:
                begin
                    i_reg     <= '0;
                    dir_reg   <= 1'b0;
                    j_reg     <= '0;
                    state_reg <= ST_FETCH;
                end
                ST_FETCH:
                    state_reg <= ST_CALC;
                ST_CALC:
                begin
                    case (op_reg)
                        CMD_PREP:
                        begin
                            t0_reg    <= is_first ? pt : sat_add(t0_reg, pt);
                            state_reg <= ST_NEXT;
                        end
                        CMD_FRONT, CMD_BACK:
                        begin
                            t0_reg    <= sat_add(umax(prev, cur), pt);
                            state_reg <= ST_NEXT;
                            if (dir_reg)
                            begin
                                bf_reg[j_reg] <= sat_add(umax(prev, cur), pt);
                                if (prev > cur)
                                    bi_reg[j_reg] <= sat_add(bi_j, prev - cur);
                            end
                            else
                            begin
                                ff_reg[j_reg] <= sat_add(umax(prev, cur), pt);
                                if (prev > cur)
                                    fi_reg[j_reg] <= sat_add(fi_j, prev - cur);
                            end
                        end
                        CMD_UNSCHED:
                        begin
                            rw_reg[j_reg] <= sat_add(rw_j, pt);
                            state_reg     <= ST_NEXT;
                        end
                        CMD_CHILD:
                        begin
                            t1_reg    <= t1_next;
                            idm_reg   <= idm_next;
                            state_reg <= ST_CALC2;
                        end
                        default:
                            state_reg <= ST_NEXT;
                    endcase
                end
                ST_CALC2:
                begin
                    t0_reg     <= sat_add(t1_reg, pt);
                    lb_acc_reg <= is_first ? lb_next : umax(lb_acc_reg, lb_next);
                    state_reg  <= is_first ? ST_DIV2 : ST_DIV1;
                end
                ST_DIV1:
                    state_reg <= ST_WAIT1;
                ST_WAIT1:
                begin
                    if (div_rsp.done)
                    begin
                        p_reg     <= prio_add(p_reg, div_rsp.quot);
                        state_reg <= is_last ? ST_NEXT : ST_DIV2;
                    end
                end
                ST_DIV2:
                    state_reg <= ST_WAIT2;
                ST_WAIT2:
                begin
                    if (div_rsp.done)
                    begin
                        p_reg     <= prio_add(p_reg, div_rsp.quot);
                        state_reg <= ST_NEXT;
                    end
                end
                ST_NODE:
                begin
                    t0_reg     <= umax(sat_add(ef_j, rw_j), t0_reg);
                    lb_acc_reg <= umax(lb_acc_reg,
                                       sat_add(umax(sat_add(ef_j, rw_j), t0_reg), eb_j));
                    state_reg  <= ST_NEXT;
                end
                ST_NEXT:
                begin
                    if (!is_last)
                    begin
                        j_reg     <= dir_reg ? (j_reg - MB'(1)) : (j_reg + MB'(1));
                        state_reg <= (op_reg == CMD_NODE) ? ST_NODE : ST_FETCH;
                    end
                    else
                    begin
                        case (op_reg)
                            CMD_PREP:
                            begin
                                if (i_reg != nj_last)
                                begin
                                    i_reg     <= i_reg + JB'(1);
                                    j_reg     <= dir_reg ? m_last : '0;
                                    state_reg <= ST_FETCH;
                                end
                                else if (!dir_reg)
                                begin
                                    i_reg     <= '0;
                                    dir_reg   <= 1'b1;
                                    j_reg     <= m_last;
                                    state_reg <= ST_FETCH;
                                end
                                else
                                    state_reg <= ST_IDLE;
                            end
                            CMD_FRONT:
                            begin
                                front_used_reg <= 1'b1;
                                state_reg      <= ST_IDLE;
                            end
                            CMD_BACK:
                            begin
                                back_used_reg <= 1'b1;
                                state_reg     <= ST_IDLE;
                            end
                            CMD_CHILD:
                            begin
                                if (!dir_reg)
                                begin
                                    lbf_reg   <= lb_acc_reg;
                                    pf_reg    <= p_reg;
                                    p_reg     <= '0;
                                    dir_reg   <= 1'b1;
                                    j_reg     <= m_last;
                                    state_reg <= ST_FETCH;
                                end
                                else
                                    state_reg <= ST_RESULT;
                            end
                            CMD_NODE:
                                state_reg <= ST_RESULT;
                            default:
                                state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_RESULT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        state_reg <= ST_IDLE;
                        if (op_reg == CMD_NODE)
                        begin
                            kind_reg <= 1'b1;
                            echo_reg <= '0;
                            bb_reg   <= '0;
                            be_reg   <= '0;
                            pb_reg   <= '0;
                            pe_reg   <= '0;
                            nb_reg   <= lb_acc_reg;
                            lf_reg   <= ff_reg[m_last];
                        end
                        else
                        begin
                            kind_reg <= 1'b0;
                            echo_reg <= job_reg;
                            bb_reg   <= lbf_reg;
                            be_reg   <= lb_acc_reg;
                            pb_reg   <= front_used_reg ? pf_reg : '0;
                            pe_reg   <= back_used_reg ? p_reg : '0;
                            nb_reg   <= '0;
                            lf_reg   <= '0;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tdata  = {2'b00, lf_reg, nb_reg, pe_reg, pb_reg, be_reg, bb_reg, echo_reg};

endmodule
`default_nettype wire

### test/fcb_bound_checker.sv
`timescale 1ns / 100ps
module fcb_bound_checker
    import fcb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [159:0] m_axis_tdata,
    input  wire logic         m_axis_tuser,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic         cfg_index,
    input  wire logic [8:0]   cfg_data,
    output int                errors,
    output int                pending
);

    localparam int unsigned VMAX = 32'h3FF_FFFF;
    localparam longint unsigned PMAX = 64'h7F_FFFF;

    typedef struct {
        bit        kind;
        bit [7:0]  job_echo;
        bit [25:0] bound_begin;
        bit [25:0] bound_end;
        bit [22:0] prio_begin;
        bit [22:0] prio_end;
        bit [25:0] node_bound;
        bit [25:0] last_finish;
    } bound_res_t;

    bound_res_t bounds_due[$];

    bit [15:0]   ptimes [8192];
    int unsigned head_min [32];
    int unsigned tail_min [32];
    int unsigned fr_fin [32];
    int unsigned bk_fin [32];
    int unsigned fr_idle [32];
    int unsigned bk_idle [32];
    int unsigned rem_work [32];
    bit          fr_used;
    bit          bk_used;
    int unsigned job_cnt_reg;
    int unsigned mach_cnt_reg;

    function automatic int unsigned sat(int unsigned a, int unsigned b);
        longint unsigned s;
        s = longint'(a) + longint'(b);
        return (s > VMAX) ? VMAX : int'(s);
    endfunction

    function automatic int unsigned mx(int unsigned a, int unsigned b);
        return (a > b) ? a : b;
    endfunction

    function automatic longint unsigned frac_div(int unsigned num, int unsigned den);
        if (den == 0)
        begin
            return 0;
        end
        return (longint'(num) << 16) / longint'(den);
    endfunction

    function automatic longint unsigned prio_sum(longint unsigned p, longint unsigned q);
        return (p + q > PMAX) ? PMAX : p + q;
    endfunction

    function int unsigned ptime(int j, int k);
        return ptimes[j * 32 + k];
    endfunction

    function int active_jobs();
        if (job_cnt_reg < 1)
        begin
            return 1;
        end
        return (job_cnt_reg > 256) ? 256 : job_cnt_reg;
    endfunction

    function int active_machs();
        if (mach_cnt_reg < 1)
        begin
            return 1;
        end
        return (mach_cnt_reg > 32) ? 32 : mach_cnt_reg;
    endfunction

    function int unsigned eff_fr(int k);
        return fr_used ? fr_fin[k] : head_min[k];
    endfunction

    function int unsigned eff_bk(int k);
        return bk_used ? bk_fin[k] : tail_min[k];
    endfunction

    function void clear_sched();
        for (int k = 0; k < 32; k++)
        begin
            fr_fin[k] = 0;
            bk_fin[k] = 0;
            fr_idle[k] = 0;
            bk_idle[k] = 0;
            rem_work[k] = 0;
        end
        fr_used = 0;
        bk_used = 0;
    endfunction

    function void prepare_heads_tails();
        int m;
        int n;
        int unsigned acc [32];
        m = active_machs();
        n = active_jobs();
        for (int k = 0; k < m; k++)
        begin
            head_min[k] = VMAX;
            tail_min[k] = VMAX;
        end
        head_min[0] = 0;
        tail_min[m-1] = 0;
        for (int i = 0; i < n; i++)
        begin
            acc[0] = ptime(i, 0);
            for (int k = 1; k < m; k++)
                acc[k] = sat(acc[k-1], ptime(i, k));
            for (int k = 1; k < m; k++)
                if (acc[k-1] < head_min[k])
                    head_min[k] = acc[k-1];
        end
        for (int i = 0; i < n; i++)
        begin
            acc[m-1] = ptime(i, m-1);
            for (int k = m - 2; k >= 0; k--)
                acc[k] = sat(acc[k+1], ptime(i, k));
            for (int k = m - 2; k >= 0; k--)
                if (acc[k+1] < tail_min[k])
                    tail_min[k] = acc[k+1];
        end
    endfunction

    function void append_front(int j);
        int m;
        m = active_machs();
        fr_fin[0] = sat(fr_fin[0], ptime(j, 0));
        for (int k = 1; k < m; k++)
        begin
            if (fr_fin[k-1] > fr_fin[k])
                fr_idle[k] = sat(fr_idle[k], fr_fin[k-1] - fr_fin[k]);
            fr_fin[k] = sat(mx(fr_fin[k-1], fr_fin[k]), ptime(j, k));
        end
        fr_used = 1;
    endfunction

    function void prepend_back(int j);
        int m;
        m = active_machs();
        bk_fin[m-1] = sat(bk_fin[m-1], ptime(j, m-1));
        for (int k = m - 2; k >= 0; k--)
        begin
            if (bk_fin[k+1] > bk_fin[k])
                bk_idle[k] = sat(bk_idle[k], bk_fin[k+1] - bk_fin[k]);
            bk_fin[k] = sat(mx(bk_fin[k], bk_fin[k+1]), ptime(j, k));
        end
        bk_used = 1;
    endfunction

    function bound_res_t predict_child(int j);
        bound_res_t r;
        int m;
        int unsigned t0;
        int unsigned t1;
        int unsigned lb;
        int unsigned lbf;
        int unsigned lbb;
        int unsigned idm;
        longint unsigned pf;
        longint unsigned pb;
        m = active_machs();
        t0 = sat(eff_fr(0), ptime(j, 0));
        lbf = sat(sat(eff_fr(0), rem_work[0]), eff_bk(0));
        pf = prio_sum(0, frac_div(bk_idle[0], eff_bk(0)));
        for (int k = 1; k < m; k++)
        begin
            idm = sat(fr_idle[k], (t0 > eff_fr(k)) ? t0 - eff_fr(k) : 0);
            t1 = mx(eff_fr(k), t0);
            lb = sat(sat(t1, rem_work[k]), eff_bk(k));
            t0 = sat(t1, ptime(j, k));
            pf = prio_sum(pf, frac_div(idm, t0));
            if (k != m - 1)
                pf = prio_sum(pf, frac_div(bk_idle[k], eff_bk(k)));
            lbf = mx(lbf, lb);
        end
        t0 = sat(eff_bk(m-1), ptime(j, m-1));
        lbb = sat(sat(eff_fr(m-1), rem_work[m-1]), eff_bk(m-1));
        pb = prio_sum(0, frac_div(fr_idle[m-1], eff_fr(m-1)));
        for (int k = m - 2; k >= 0; k--)
        begin
            idm = sat(bk_idle[k], (t0 > eff_bk(k)) ? t0 - eff_bk(k) : 0);
            t1 = mx(t0, eff_bk(k));
            lb = sat(sat(eff_fr(k), rem_work[k]), t1);
            t0 = sat(t1, ptime(j, k));
            pb = prio_sum(pb, frac_div(idm, t0));
            if (k != 0)
                pb = prio_sum(pb, frac_div(fr_idle[k], eff_fr(k)));
            lbb = mx(lbb, lb);
        end
        r = '{default: 0};
        r.job_echo = j[7:0];
        r.bound_begin = lbf[25:0];
        r.bound_end = lbb[25:0];
        r.prio_begin = fr_used ? pf[22:0] : 23'd0;
        r.prio_end = bk_used ? pb[22:0] : 23'd0;
        return r;
    endfunction

    function bound_res_t predict_node();
        bound_res_t r;
        int m;
        int unsigned t0;
        int unsigned t1;
        int unsigned lb;
        m = active_machs();
        t0 = sat(eff_fr(0), rem_work[0]);
        lb = sat(t0, eff_bk(0));
        for (int k = 1; k < m; k++)
        begin
            t1 = mx(sat(eff_fr(k), rem_work[k]), t0);
            lb = mx(lb, sat(t1, eff_bk(k)));
            t0 = t1;
        end
        r = '{default: 0};
        r.kind = 1;
        r.node_bound = lb[25:0];
        r.last_finish = fr_fin[m-1][25:0];
        return r;
    endfunction

    function void cmp(string fld, longint unsigned e, longint unsigned a);
        if (e != a)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, e, a);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bound_res_t e;
        int j;
        int m;
        cmd_t c;
        if (!rst_n)
        begin
            clear_sched();
            for (int k = 0; k < 32; k++)
            begin
                head_min[k] = 0;
                tail_min[k] = 0;
            end
            job_cnt_reg = 256;
            mach_cnt_reg = 32;
            bounds_due.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (bounds_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual tdata %h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    e = bounds_due.pop_front();
                    cmp("kind", e.kind, m_axis_tuser);
                    cmp("job_echo", e.job_echo, m_axis_tdata[7:0]);
                    cmp("bound_begin", e.bound_begin, m_axis_tdata[33:8]);
                    cmp("bound_end", e.bound_end, m_axis_tdata[59:34]);
                    cmp("prio_begin", e.prio_begin, m_axis_tdata[82:60]);
                    cmp("prio_end", e.prio_end, m_axis_tdata[105:83]);
                    cmp("node_bound", e.node_bound, m_axis_tdata[131:106]);
                    cmp("last_finish", e.last_finish, m_axis_tdata[157:132]);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_JOB_COUNT)
                    job_cnt_reg = cfg_data;
                else
                    mach_cnt_reg = cfg_data[5:0];
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                c = s_axis_tdata[2:0];
                j = s_axis_tdata[10:3];
                case (c)
                    CMD_LOAD:
                        ptimes[j * 32 + s_axis_tdata[15:11]] = s_axis_tdata[31:16];
                    CMD_PREP:
                        prepare_heads_tails();
                    CMD_CLEAR:
                        clear_sched();
                    CMD_FRONT:
                        append_front(j);
                    CMD_BACK:
                        prepend_back(j);
                    CMD_UNSCHED:
                    begin
                        m = active_machs();
                        for (int k = 0; k < m; k++)
                            rem_work[k] = sat(rem_work[k], ptime(j, k));
                    end
                    CMD_CHILD:
                        bounds_due.push_back(predict_child(j));
                    default:
                        bounds_due.push_back(predict_node());
                endcase
            end
            pending = bounds_due.size();
        end
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import fcb_pkg::*;

    localparam int LIMIT = 6000000;
    localparam int SETTLE = 2500;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [159:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic         cfg_index = 0;
    logic [8:0]   cfg_data = '0;

    int  errors;
    int  pending;
    int  cycles = 0;
    int  src_idle = 0;
    int  dst_idle = 0;
    bit  squeeze = 0;
    bit  loaded [256][32];
    int  n_jobs;
    int  n_mach;

    flowshop_child_bound_engine uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    fcb_bound_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1;
        #4;
        clk = 0;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side; one long hold-off to back the block up
    initial
    begin
        bit squeezed;
        squeezed = 0;
        forever
        begin
            @(posedge clk);
            if (squeeze && !squeezed)
            begin
                squeezed = 1;
                m_axis_tready <= 0;
                repeat (3000) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(99) >= dst_idle);
        end
    end

    task automatic send(cmd_t c, int j, int mi, int pt);
        if ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 0;
            do @(posedge clk); while ($urandom_range(99) < src_idle);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {pt[15:0], mi[4:0], j[7:0], c};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (c == CMD_LOAD)
            loaded[j][mi] = 1;
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(logic idx, int v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v[8:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    function automatic int rand_time();
        case ($urandom_range(9))
            0: return 0;
            1: return 65535;
            2, 3: return $urandom_range(65535);
            default: return $urandom_range(200);
        endcase
    endfunction

    // only jobs with every active machine loaded may be scheduled or queried
    function automatic int rand_job();
        int j;
        bit ok;
        repeat (6)
        begin
            j = $urandom_range(255);
            ok = 1;
            for (int k = 0; k < n_mach; k++)
                if (!loaded[j][k])
                    ok = 0;
            if (ok)
                return j;
        end
        return $urandom_range(n_jobs - 1);
    endfunction

    task automatic setup_phase(int jc, int mc, int s_idle, int d_idle);
        drain();
        cfg_write(CFG_JOB_COUNT, jc);
        cfg_write(CFG_MACHINE_COUNT, mc);
        cfg_valid <= 0;
        src_idle = s_idle;
        dst_idle = d_idle;
        n_jobs = (jc == 0) ? 1 : ((jc > 256) ? 256 : jc);
        n_mach = ((mc & 63) == 0) ? 1 : (((mc & 63) > 32) ? 32 : (mc & 63));
        for (int j = 0; j < n_jobs; j++)
            for (int k = 0; k < n_mach; k++)
                if (!loaded[j][k])
                    send(CMD_LOAD, j, k, rand_time());
        send(CMD_PREP, 0, 0, 0);
        send(CMD_CLEAR, 0, 0, 0);
    endtask

    task automatic random_run(int count, int clear_pct);
        int r;
        repeat (count)
        begin
            r = $urandom_range(99);
            if (r < 8)
                send(CMD_LOAD, $urandom_range(255), $urandom_range(31), rand_time());
            else if (r < 8 + clear_pct)
                send(CMD_CLEAR, rand_job(), $urandom_range(31), rand_time());
            else if (r < 10 + clear_pct)
                send(CMD_PREP, rand_job(), $urandom_range(31), rand_time());
            else if (r < 27 + clear_pct)
                send(CMD_FRONT, rand_job(), $urandom_range(31), rand_time());
            else if (r < 44 + clear_pct)
                send(CMD_BACK, rand_job(), $urandom_range(31), rand_time());
            else if (r < 58 + clear_pct)
                send(CMD_UNSCHED, rand_job(), $urandom_range(31), rand_time());
            else if (r < 68 + clear_pct)
                send(CMD_NODE, rand_job(), $urandom_range(31), rand_time());
            else
                send(CMD_CHILD, rand_job(), $urandom_range(31), rand_time());
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        setup_phase(3, 4, 24, 46);
        // job 0 all maximal, job 2 all zero: zero divisors once job 2 leads
        for (int k = 0; k < 4; k++)
        begin
            send(CMD_LOAD, 0, k, 65535);
            send(CMD_LOAD, 1, k, $urandom_range(65535));
            send(CMD_LOAD, 2, k, 0);
        end
        send(CMD_PREP, 0, 0, 0);
        send(CMD_NODE, 0, 0, 0);
        send(CMD_CHILD, 1, 0, 0);
        send(CMD_FRONT, 2, 0, 0);
        send(CMD_CHILD, 2, 0, 0);
        send(CMD_NODE, 0, 0, 0);
        send(CMD_BACK, 0, 0, 0);
        send(CMD_UNSCHED, 1, 0, 0);
        send(CMD_CHILD, 0, 0, 0);
        send(CMD_CHILD, 1, 0, 0);
        send(CMD_NODE, 0, 0, 0);
        send(CMD_CLEAR, 0, 0, 0);
        send(CMD_FRONT, 0, 0, 0);
        send(CMD_FRONT, 0, 0, 0);
        send(CMD_CHILD, 1, 0, 0);
        send(CMD_NODE, 0, 0, 0);
        random_run(200, 5);

        setup_phase(511, 0, 24, 46);
        random_run(100, 1);
        squeeze = 1;
        random_run(300, 1);

        setup_phase(0, 32, 46, 24);
        random_run(40, 4);

        setup_phase(5, 2, 46, 24);
        random_run(250, 4);

        setup_phase(8, 3, 0, 0);
        random_run(250, 3);

        setup_phase(2, 63, 0, 0);
        random_run(40, 4);

        setup_phase(1, 1, 0, 0);
        random_run(150, 2);

        setup_phase(6, 8, 0, 0);
        random_run(150, 5);

        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
